FILE: src/sogi_quadrature_filter_assert.svh
// ----------------------------------------------------------------------------
// SOGI quadrature filter assertion macros
// Shared property wrappers clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SOGI_QUADRATURE_FILTER_ASSERT_SVH
`define SOGI_QUADRATURE_FILTER_ASSERT_SVH

// same-cycle implication
`define SQF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SQF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sqf_pkg.sv
// ----------------------------------------------------------------------------
// SOGI quadrature filter package
// Widths, register indexes, sequencer types and saturation helpers.
// ----------------------------------------------------------------------------
package sqf_pkg;

    localparam int SampleBitsDef = 16;
    localparam int DelayBitsDef  = 48;
    localparam int OutBits       = 18;
    localparam int DlyFrac       = 24;
    localparam int CoefFrac      = 30;
    localparam int CoefW         = 37;
    localparam int CoefMagW      = 36;
    localparam int FreqBits      = 20;
    localparam int PeriodBits    = 32;
    localparam int GainBits      = 16;
    localparam int OffsetBits    = 16;
    localparam int CfgIdxW       = 2;
    localparam int CfgDataW      = 32;
    localparam int DigitW        = 16;
    localparam int Digits        = 4;
    localparam int MacW          = 100;
    localparam int DivSteps      = 32;
    localparam int CntW          = 5;

    localparam logic [PeriodBits-1:0] PeriodReset = 32'd429497;
    localparam logic [GainBits-1:0]   GainReset   = 16'd5793;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_OFFSET = 2'd0,
        CFG_PERIOD = 2'd1,
        CFG_GAIN   = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MX, ST_MSQ, ST_MKX, ST_SUMD, ST_NORM, ST_DIVI, ST_DIV,
        ST_MBP, ST_MCS, ST_MQ0, ST_COEF, ST_FLOAD, ST_FRUN, ST_FACC, ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_MX, OP_MSQ, OP_MKX, OP_SUMD, OP_NORM, OP_DIVI,
        OP_DIV, OP_MBP, OP_MCS, OP_MQ0, OP_COEF, OP_FLOAD, OP_FRUN, OP_FACC,
        OP_OUT
    } t_dp_op;

    // filter products in issue order
    typedef enum logic [3:0] {
        P_A1_WA1, P_A2_WA2, P_BP_INA, P_NBP_WA2,
        P_A1_WB1, P_A2_WB2, P_Q0_INB, P_Q02_WB1, P_Q0_WB2
    } t_prod;

    typedef struct packed {
        t_dp_op op;
        t_prod  prod;
    } t_dp_cmd;

    typedef struct packed {
        logic norm_done;
        logic out_free;
    } t_dp_status;

    function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
        logic signed [63:0] r;
        if (v[64] != v[63]) begin
            r = v[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            r = v[63:0];
        end
        return r;
    endfunction

    // floor by 2^24, then saturate to the output width
    function automatic logic [OutBits-1:0] to_out(input logic signed [63:0] v);
        logic signed [39:0] r;
        logic [OutBits-1:0] o;
        r = $signed(v[63:24]);
        if (r > 40'sd131071) begin
            o = 18'h1FFFF;
        end else if (r < -40'sd131072) begin
            o = 18'h20000;
        end else begin
            o = r[OutBits-1:0];
        end
        return o;
    endfunction

endpackage

FILE: src/sqf_ctrl.sv
// ----------------------------------------------------------------------------
// SOGI quadrature filter sequencer
// Steps the datapath through coefficient, reciprocal and biquad phases.
// ----------------------------------------------------------------------------
module sqf_ctrl import sqf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    t_prod           r_prod, n_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_prod  <= P_A1_WA1;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_prod  <= n_prod;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_prod  = r_prod;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_MX;
            end
            ST_MX:   n_state = ST_MSQ;
            ST_MSQ:  n_state = ST_MKX;
            ST_MKX:  n_state = ST_SUMD;
            ST_SUMD: n_state = ST_NORM;
            ST_NORM: begin
                if (i_status.norm_done) n_state = ST_DIVI;
            end
            ST_DIVI: begin
                n_state = ST_DIV;
                n_cnt   = '0;
            end
            ST_DIV: begin
                if (r_cnt == CntW'(DivSteps - 1)) begin
                    n_state = ST_MBP;
                end else begin
                    n_cnt = r_cnt + CntW'(1);
                end
            end
            ST_MBP:  n_state = ST_MCS;
            ST_MCS:  n_state = ST_MQ0;
            ST_MQ0:  n_state = ST_COEF;
            ST_COEF: begin
                n_state = ST_FLOAD;
                n_prod  = P_A1_WA1;
            end
            ST_FLOAD: begin
                n_state = ST_FRUN;
                n_cnt   = '0;
            end
            ST_FRUN: begin
                if (r_cnt == CntW'(Digits - 1)) begin
                    n_state = ST_FACC;
                end else begin
                    n_cnt = r_cnt + CntW'(1);
                end
            end
            ST_FACC: begin
                if (r_prod == P_Q0_WB2) begin
                    n_state = ST_OUT;
                end else begin
                    n_prod  = t_prod'(r_prod + 4'd1);
                    n_state = ST_FLOAD;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.prod = r_prod;
        o_cmd.op   = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_LOAD;
            end
            ST_MX:    o_cmd.op = OP_MX;
            ST_MSQ:   o_cmd.op = OP_MSQ;
            ST_MKX:   o_cmd.op = OP_MKX;
            ST_SUMD:  o_cmd.op = OP_SUMD;
            ST_NORM:  o_cmd.op = OP_NORM;
            ST_DIVI:  o_cmd.op = OP_DIVI;
            ST_DIV:   o_cmd.op = OP_DIV;
            ST_MBP:   o_cmd.op = OP_MBP;
            ST_MCS:   o_cmd.op = OP_MCS;
            ST_MQ0:   o_cmd.op = OP_MQ0;
            ST_COEF:  o_cmd.op = OP_COEF;
            ST_FLOAD: o_cmd.op = OP_FLOAD;
            ST_FRUN:  o_cmd.op = OP_FRUN;
            ST_FACC:  o_cmd.op = OP_FACC;
            ST_OUT: begin
                if (i_status.out_free) o_cmd.op = OP_OUT;
            end
            default:  o_cmd.op = OP_NONE;
        endcase
    end

endmodule

FILE: src/sqf_datapath.sv
// ----------------------------------------------------------------------------
// SOGI quadrature filter datapath
// Config registers, coefficient multiplier, reciprocal divider, serial
// coefficient-by-delay multiplier, saturating accumulate and output register.
// ----------------------------------------------------------------------------
module sqf_datapath import sqf_pkg::*; #(
    parameter int SAMPLE_BITS = SampleBitsDef,
    parameter int DELAY_BITS  = DelayBitsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_status                    o_status,
    input  logic                          i_cfg_valid,
    input  logic [CfgIdxW-1:0]            i_cfg_index,
    input  logic [CfgDataW-1:0]           i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [FreqBits-1:0]           i_angular_freq,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [OutBits-1:0]            o_in_phase,
    output logic [OutBits-1:0]            o_quadrature
);

    localparam logic signed [63:0] DlyMax = (64'sd1 <<< (DELAY_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] DlyMin = -DlyMax - 64'sd1;
    localparam logic [CoefW-1:0]   CoefOne = CoefW'(64'd1 << CoefFrac);

    // configuration
    logic [OffsetBits-1:0] r_offset;
    logic [PeriodBits-1:0] r_period;
    logic [GainBits-1:0]   r_gain;

    // coefficient path
    logic [FreqBits-1:0] r_af;
    logic signed [63:0]  r_u24;
    logic [31:0]         r_xq;
    logic [62:0]         r_sq;
    logic [55:0]         r_kx;
    logic [63:0]         r_d;
    logic [55:0]         r_kn;
    logic [62:0]         r_sn;
    logic [32:0]         r_rem;
    logic [32:0]         r_q;
    logic [31:0]         r_bp;
    logic [31:0]         r_cs;
    logic [34:0]         r_q0;
    logic [CoefW-1:0]    r_a1, r_a2;

    // filter path
    logic signed [DELAY_BITS-1:0] r_wa1, r_wa2, r_wb1, r_wb2, r_in;
    logic [CoefMagW-1:0]          r_mc;
    logic [63:0]                  r_mx;
    logic                         r_neg;
    logic [MacW-1:0]              r_acc;
    logic signed [63:0]           r_s, r_y;
    logic [OutBits-1:0]           r_oa, r_ob;
    logic                         r_tvalid;

    logic [32:0] mul_a, mul_b;
    logic [65:0] mul_p;

    logic signed [SAMPLE_BITS:0] ld_u;
    logic [SAMPLE_BITS-1:0]      off_t;

    logic [31:0] dn;
    logic [32:0] rem_sh;

    logic [CoefW-1:0]    sum_a1;
    logic [CoefW-1:0]    f_coef;
    logic signed [63:0]  f_opnd;
    logic [CoefMagW-1:0] coef_mag;
    logic [63:0]         opnd_mag;

    logic [62:0]        mag63;
    logic signed [63:0] f_t;
    logic signed [63:0] f_dif_src;
    logic signed [63:0] f_dif;
    logic signed [63:0] f_clamp;
    logic signed [63:0] f_sum;

    assign mul_p = mul_a * mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_MX: begin
                mul_a = 33'(r_af);
                mul_b = 33'(r_period);
            end
            OP_MSQ: begin
                mul_a = 33'(r_xq);
                mul_b = 33'(r_xq);
            end
            OP_MKX: begin
                mul_a = 33'(r_gain);
                mul_b = 33'(r_xq);
            end
            OP_MBP: begin
                mul_a = 33'(r_kn[31:0]);
                mul_b = r_q;
            end
            OP_MCS: begin
                mul_a = 33'(r_sn[31:0]);
                mul_b = r_q;
            end
            OP_MQ0: begin
                mul_a = 33'(r_cs);
                mul_b = 33'(r_gain);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // offset is taken at sample width as an unsigned field, then sign-extended
    assign off_t = SAMPLE_BITS'(r_offset);
    assign ld_u  = (SAMPLE_BITS + 1)'(i_sample) - (SAMPLE_BITS + 1)'($signed(off_t));

    assign dn     = r_d[31:0];
    assign rem_sh = {r_rem[31:0], 1'b0};
    assign sum_a1 = CoefW'({r_cs, 1'b0}) + CoefW'(r_bp) - CoefOne;

    always_comb begin
        f_coef = '0;
        f_opnd = '0;
        case (i_cmd.prod)
            P_A1_WA1: begin
                f_coef = r_a1;
                f_opnd = 64'(r_wa1);
            end
            P_A2_WA2: begin
                f_coef = r_a2;
                f_opnd = 64'(r_wa2);
            end
            P_BP_INA: begin
                f_coef = CoefW'(r_bp);
                f_opnd = 64'(r_in);
            end
            P_NBP_WA2: begin
                f_coef = CoefW'(0) - CoefW'(r_bp);
                f_opnd = 64'(r_wa2);
            end
            P_A1_WB1: begin
                f_coef = r_a1;
                f_opnd = 64'(r_wb1);
            end
            P_A2_WB2: begin
                f_coef = r_a2;
                f_opnd = 64'(r_wb2);
            end
            P_Q0_INB: begin
                f_coef = CoefW'(r_q0);
                f_opnd = 64'(r_in);
            end
            P_Q02_WB1: begin
                f_coef = CoefW'({r_q0, 1'b0});
                f_opnd = 64'(r_wb1);
            end
            P_Q0_WB2: begin
                f_coef = CoefW'(r_q0);
                f_opnd = 64'(r_wb2);
            end
            default: begin
                f_coef = '0;
                f_opnd = '0;
            end
        endcase
    end

    assign coef_mag = f_coef[CoefW-1] ? CoefMagW'(CoefW'(0) - f_coef) : f_coef[CoefMagW-1:0];
    assign opnd_mag = f_opnd[63] ? 64'd0 - 64'(f_opnd) : 64'(f_opnd);

    // product >> 30, truncated, saturated to int64 magnitude
    assign mag63 = (|r_acc[MacW-1:93]) ? {63{1'b1}} : r_acc[92:30];
    assign f_t   = r_neg ? -$signed({1'b0, mag63}) : $signed({1'b0, mag63});

    assign f_dif_src = (i_cmd.prod == P_A1_WA1 || i_cmd.prod == P_A1_WB1) ? r_u24 : r_s;
    assign f_dif     = sat64({f_dif_src[63], f_dif_src} - {f_t[63], f_t});
    assign f_clamp   = (f_dif > DlyMax) ? DlyMax : ((f_dif < DlyMin) ? DlyMin : f_dif);
    assign f_sum     = sat64({r_y[63], r_y} + {f_t[63], f_t});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_period <= PeriodReset;
            r_gain   <= GainReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OFFSET: r_offset <= i_cfg_data[OffsetBits-1:0];
                CFG_PERIOD: r_period <= i_cfg_data[PeriodBits-1:0];
                CFG_GAIN:   r_gain   <= i_cfg_data[GainBits-1:0];
                default:    r_offset <= r_offset;
            endcase
        end
    end

    // delay state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wa1 <= '0;
            r_wa2 <= '0;
            r_wb1 <= '0;
            r_wb2 <= '0;
        end else if (i_cmd.op == OP_LOAD && i_restart) begin
            r_wa1 <= '0;
            r_wa2 <= '0;
            r_wb1 <= '0;
            r_wb2 <= '0;
        end else if (i_cmd.op == OP_FACC && i_cmd.prod == P_NBP_WA2) begin
            r_wa2 <= r_wa1;
            r_wa1 <= r_in;
        end else if (i_cmd.op == OP_FACC && i_cmd.prod == P_Q0_WB2) begin
            r_wb2 <= r_wb1;
            r_wb1 <= r_in;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_af  <= i_angular_freq;
                r_u24 <= 64'(ld_u) <<< DlyFrac;
            end
            OP_MX:  r_xq <= mul_p[51:20];
            OP_MSQ: r_sq <= mul_p[63:1];
            OP_MKX: r_kx <= {mul_p[47:0], 8'd0};
            OP_SUMD: begin
                r_d  <= (64'd1 << 41) + 64'(r_kx) + 64'(r_sq);
                r_kn <= r_kx;
                r_sn <= r_sq;
            end
            OP_NORM: begin
                if (r_d[63:32] != 32'd0) begin
                    r_d  <= r_d >> 1;
                    r_kn <= r_kn >> 1;
                    r_sn <= r_sn >> 1;
                end
            end
            OP_DIVI: begin
                // 2^63 / dn: upper quotient bit is set only for dn == 2^31
                if (dn == 32'h8000_0000) begin
                    r_rem <= '0;
                    r_q   <= {1'b1, 32'd0};
                end else begin
                    r_rem <= 33'h0_8000_0000;
                    r_q   <= '0;
                end
            end
            OP_DIV: begin
                if (rem_sh >= 33'(dn)) begin
                    r_rem <= rem_sh - 33'(dn);
                    r_q   <= {r_q[32], r_q[30:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_q   <= {r_q[32], r_q[30:0], 1'b0};
                end
            end
            OP_MBP: r_bp <= mul_p[64:33];
            OP_MCS: r_cs <= mul_p[64:33];
            OP_MQ0: r_q0 <= mul_p[46:12];
            OP_COEF: begin
                r_a1 <= {sum_a1[CoefW-2:0], 1'b0};
                r_a2 <= CoefOne - CoefW'({r_bp, 1'b0});
            end
            OP_FLOAD: begin
                r_mc  <= coef_mag;
                r_mx  <= opnd_mag;
                r_neg <= f_coef[CoefW-1] ^ f_opnd[63];
                r_acc <= '0;
            end
            OP_FRUN: begin
                r_acc <= {r_acc[MacW-DigitW-1:0], {DigitW{1'b0}}}
                       + MacW'(r_mc * r_mx[63:64-DigitW]);
                r_mx  <= r_mx << DigitW;
            end
            OP_FACC: begin
                case (i_cmd.prod)
                    P_A1_WA1, P_A1_WB1: r_s  <= f_dif;
                    P_A2_WA2, P_A2_WB2: r_in <= f_clamp[DELAY_BITS-1:0];
                    P_BP_INA, P_Q0_INB: r_y  <= f_t;
                    P_Q02_WB1:          r_y  <= f_sum;
                    P_NBP_WA2:          r_oa <= to_out(f_sum);
                    P_Q0_WB2:           r_ob <= to_out(f_sum);
                    default:            r_y  <= r_y;
                endcase
            end
            OP_OUT: begin
                o_in_phase   <= r_oa;
                o_quadrature <= r_ob;
            end
            default: r_af <= r_af;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_tvalid <= 1'b1;
        end else if (i_out_ready) begin
            r_tvalid <= 1'b0;
        end
    end

    assign o_out_valid        = r_tvalid;
    assign o_status.out_free  = !r_tvalid || i_out_ready;
    assign o_status.norm_done = (r_d[63:32] == 32'd0);

endmodule

FILE: src/sogi_quadrature_filter.sv
// ----------------------------------------------------------------------------
// SOGI quadrature filter
// Offset removal, per-sample SOGI coefficients and two shared-pole biquads
// giving in-phase and quadrature outputs.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tdata = {angular_freq, sample}, tuser = restart. One request
//   is taken when the block is idle; tready stays low while it is processed.
//   Master stream: tdata = {quadrature, in_phase}, one result per request.
//   Config channel: index 0 offset, 1 sample period, 2 gain; always ready.
//   Write it only while no request is in flight. Other indexes are ignored.
// Sequencing:
//   After accept the block normalises the denominator by shifting, runs the
//   restoring reciprocal, then forms the nine coefficient-by-delay products
//   one after another on a 36x16 multiplier. Items do not overlap: a new
//   request is taken only once the previous result is in the output register.
// Reset: i_rst_n low clears delays, loads default config, drops tvalid.
// Receiver stall: the finished result sits in the output register; the
//   block takes one more request, works it through and then waits, taking
//   no further request until the output register is free.
// ----------------------------------------------------------------------------
module sogi_quadrature_filter import sqf_pkg::*; #(
    parameter int SAMPLE_BITS = SampleBitsDef,
    parameter int DELAY_BITS  = DelayBitsDef
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    // [SAMPLE_BITS-1:0] sample, then angular_freq (20), zero padded
    input  logic [((SAMPLE_BITS+FreqBits+7)/8)*8-1:0]   i_s_axis_tdata,
    // [0] restart
    input  logic                                        i_s_axis_tuser,
    output logic                                        o_m_axis_tvalid,
    input  logic                                        i_m_axis_tready,
    // [17:0] in_phase, [35:18] quadrature, zero padded
    output logic [((2*OutBits+7)/8)*8-1:0]              o_m_axis_tdata,
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [CfgIdxW-1:0]                          i_cfg_index,
    input  logic [CfgDataW-1:0]                         i_cfg_data
);

    localparam int OutTdataW = ((2 * OutBits + 7) / 8) * 8;

    t_dp_cmd            dp_cmd;
    t_dp_status         dp_status;
    logic [OutBits-1:0] in_phase, quadrature;

    sqf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    sqf_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DELAY_BITS  (DELAY_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample       ($signed(i_s_axis_tdata[SAMPLE_BITS-1:0])),
        .i_angular_freq (i_s_axis_tdata[SAMPLE_BITS +: FreqBits]),
        .i_restart      (i_s_axis_tuser),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_in_phase     (in_phase),
        .o_quadrature   (quadrature)
    );

    assign o_m_axis_tdata = OutTdataW'({quadrature, in_phase});
    assign o_cfg_ready    = 1'b1;

endmodule

FILE: src/sqf_checker.sv
// ----------------------------------------------------------------------------
// SOGI quadrature filter port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "sogi_quadrature_filter_assert.svh"

module sqf_checker import sqf_pkg::*; #(
    parameter int SAMPLE_BITS = SampleBitsDef
) (
    input logic                                      i_clk,
    input logic                                      i_rst_n,
    input logic                                      i_s_axis_tvalid,
    input logic                                      o_s_axis_tready,
    input logic                                      o_m_axis_tvalid,
    input logic                                      i_m_axis_tready,
    input logic [((2*OutBits+7)/8)*8-1:0]            o_m_axis_tdata,
    input logic                                      o_cfg_ready
);

    // one request at a time: busy right after taking one
    `SQF_ASSERT_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "ready high right after accept")

    // a result passes through the whole sequence, so none appears just after an accept
    `SQF_ASSERT_NEXT(a_no_instant_result, i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid, !o_m_axis_tvalid, "result too early")

    `SQF_ASSERT_SAME(a_cfg_ready, 1'b1, o_cfg_ready, "config channel not ready")

    `SQF_ASSERT_NEXT(a_hold_stalled, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

endmodule

bind sogi_quadrature_filter sqf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sqf_checker (.*);

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// SOGI quadrature filter testbench
// Predicts in-phase and quadrature outputs with its own bit-exact filter model.
// Drives bursty requests, stalls the receiver and holds it off once for a long
// stretch. Steps through several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb;
    import sqf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LIMIT     = 1000000;
    localparam int  SETTLE    = 200;
    localparam int  HOLD_LEN  = 600;
    localparam longint Q30_ONE = 64'sd1 << 30;

    // filter model plus queue of expected outputs
    class sogi_scoreboard;
        bit [15:0] offset;
        bit [31:0] period;
        bit [15:0] gain;
        longint    al1, al2, be1, be2;
        bit [17:0] exp_ip[$];
        bit [17:0] exp_qd[$];
        int        errors;

        function new();
            offset = '0;
            period = PeriodReset;
            gain   = GainReset;
            al1 = 0; al2 = 0; be1 = 0; be2 = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                CFG_OFFSET: offset = data[15:0];
                CFG_PERIOD: period = data;
                CFG_GAIN:   gain   = data[15:0];
                default: ;
            endcase
        endfunction

        // (a*b) >> 30 on magnitudes, symmetric saturation
        function longint mul_q30(longint a, longint b);
            bit         neg;
            bit [63:0]  ua, ub, mag;
            bit [127:0] p;
            neg = (a < 0) != (b < 0);
            ua  = (a < 0) ? -a : a;
            ub  = (b < 0) ? -b : b;
            p   = ({64'd0, ua} * {64'd0, ub}) >> 30;
            if (p[127:63] != 0) mag = 64'h7FFF_FFFF_FFFF_FFFF;
            else mag = p[63:0];
            return neg ? -longint'(mag) : longint'(mag);
        endfunction

        function longint sat65(logic signed [64:0] v);
            if (v[64] != v[63]) return v[64] ? 64'sh8000_0000_0000_0000
                                             : 64'sh7FFF_FFFF_FFFF_FFFF;
            return v[63:0];
        endfunction

        function longint sat_add(longint a, longint b);
            return sat65({a[63], a} + {b[63], b});
        endfunction

        function longint sat_sub(longint a, longint b);
            return sat65({a[63], a} - {b[63], b});
        endfunction

        function longint clamp48(longint v);
            longint hi;
            hi = (64'sd1 <<< 47) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        function bit [17:0] out18(longint v);
            longint r;
            r = v >>> 24;
            if (r > 131071) r = 131071;
            if (r < -131072) r = -131072;
            return r[17:0];
        endfunction

        function void note_input(logic [15:0] smp, logic [19:0] w, logic rst);
            longint    u24, bp, cs, a1, a2, q0, in_a, in_b, ya, yb;
            bit [63:0] wf, pf, kf, xq, sq, kx2, d, dn, recip;
            int        s;
            if (rst) begin
                al1 = 0; al2 = 0; be1 = 0; be2 = 0;
            end
            u24 = (longint'($signed(smp)) - longint'($signed(offset))) * (64'sd1 << 24);
            wf = w; pf = period; kf = gain;
            xq  = (wf * pf) >> 20;
            sq  = (xq * xq) >> 1;
            kx2 = (kf * xq) << 8;
            d   = (64'd1 << 41) + kx2 + sq;
            s = 0;
            while ((d >> s) > 64'hFFFF_FFFF) s++;
            dn    = d >> s;
            recip = (64'd1 << 63) / dn;
            bp = longint'(((kx2 >> s) * recip) >> 33);
            cs = longint'(((sq >> s) * recip) >> 33);
            a1 = 2 * (2 * cs + bp - Q30_ONE);
            a2 = Q30_ONE - 2 * bp;
            q0 = longint'((64'(cs) * kf) >> 12);

            in_a = clamp48(sat_sub(sat_sub(u24, mul_q30(a1, al1)), mul_q30(a2, al2)));
            ya   = sat_add(mul_q30(bp, in_a), mul_q30(-bp, al2));
            al2 = al1; al1 = in_a;

            in_b = clamp48(sat_sub(sat_sub(u24, mul_q30(a1, be1)), mul_q30(a2, be2)));
            yb   = sat_add(sat_add(mul_q30(q0, in_b), mul_q30(2 * q0, be1)),
                           mul_q30(q0, be2));
            be2 = be1; be1 = in_b;

            exp_ip.push_back(out18(ya));
            exp_qd.push_back(out18(yb));
        endfunction

        function void check_result(logic [39:0] data);
            bit [17:0] ip, qd;
            if (exp_ip.size() == 0) begin
                $error("unexpected result, tdata %h", data);
                errors++;
                return;
            end
            ip = exp_ip.pop_front();
            qd = exp_qd.pop_front();
            if (data[17:0] !== ip) begin
                $error("in_phase expected %0d got %0d", $signed(ip), $signed(data[17:0]));
                errors++;
            end
            if (data[35:18] !== qd) begin
                $error("quadrature expected %0d got %0d", $signed(qd), $signed(data[35:18]));
                errors++;
            end
        endfunction

        function int pending();
            return exp_ip.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [39:0]       i_s_axis_tdata = '0;
    logic              i_s_axis_tuser = 1'b0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [39:0]       o_m_axis_tdata;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    sogi_scoreboard sb = new();
    int  cycles = 0;
    bit  hold_req = 1'b0;
    int  hold_cnt = 0;
    int  pat_left = 0;
    int  pat_mode = 0;
    int  burst_left = 0;

    sogi_quadrature_filter i_dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // acceptance monitors, sampling pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_input(i_s_axis_tdata[15:0], i_s_axis_tdata[35:16], i_s_axis_tuser);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata);
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    // receiver: stall pattern, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_req || hold_cnt > 0) begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_LEN;
            end
            hold_cnt--;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (pat_left == 0) begin
                pat_mode = $urandom_range(0, 2);
                pat_left = $urandom_range(20, 200);
            end
            pat_left--;
            case (pat_mode)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= $urandom_range(0, 1);
                default: i_m_axis_tready <= (pat_left % 4 == 0);
            endcase
        end
    end

    // valid drops after each write, keeping back-to-back writes apart
    task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one request; valid is left high, bursts decide when it drops
    task automatic send_item(logic [15:0] smp, logic [19:0] w, logic rst);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'd0, w, smp};
        i_s_axis_tuser  <= rst;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // block idle: all results back, then a settling wait
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic random_items(int count);
        logic [15:0] smp;
        logic [19:0] w;
        logic        rst;
        repeat (count) begin
            if ($urandom_range(0, 9) < 7) begin
                // plausible line: near 50/60 Hz, moderate amplitude
                w   = $urandom_range(70000, 100000);
                smp = $urandom_range(0, 40000) - 20000;
                rst = ($urandom_range(0, 39) == 0);
            end else begin
                w   = $urandom;
                smp = $urandom;
                rst = ($urandom_range(0, 4) == 0);
            end
            send_item(smp, w, rst);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults from reset, directed corners
        send_item(16'sd1000, 20'd80425, 1'b1);
        send_item(16'h7FFF, 20'd80425, 1'b0);
        send_item(16'h8000, 20'd80425, 1'b0);
        send_item(16'd0, 20'd80425, 1'b0);
        send_item(16'h7FFF, 20'd0, 1'b0);
        send_item(16'h7FFF, 20'd0, 1'b0);
        send_item(16'h8000, 20'd0, 1'b0);
        send_item(16'h1234, 20'hFFFFF, 1'b0);
        send_item(16'h8000, 20'hFFFFF, 1'b0);
        send_item(16'h7FFF, 20'd1, 1'b1);
        send_item(16'h5555, 20'hAAAAA, 1'b0);
        send_item(16'hAAAA, 20'h55555, 1'b0);
        send_item(16'hFFFF, 20'd96510, 1'b1);
        send_item(16'd1, 20'd96510, 1'b0);
        settle();

        // offset at its low end makes sample minus offset need full width
        write_cfg(CFG_OFFSET, 32'hFFFF_8000);
        write_cfg(CFG_PERIOD, 32'hFFFF_FFFF);
        write_cfg(CFG_GAIN, 32'd65535);
        send_item(16'h7FFF, 20'hFFFFF, 1'b1);
        send_item(16'h7FFF, 20'd0, 1'b0);
        hold_req = 1'b1;
        random_items(90);
        settle();

        write_cfg(CFG_OFFSET, 32'd32767);
        write_cfg(CFG_PERIOD, 32'd1);
        write_cfg(CFG_GAIN, 32'd0);
        send_item(16'h8000, 20'hFFFFF, 1'b1);
        random_items(90);
        settle();

        // index outside the register map must be ignored
        write_cfg(2'd3, 32'hDEAD_BEEF);
        write_cfg(CFG_OFFSET, 32'd0);
        write_cfg(CFG_PERIOD, PeriodReset);
        write_cfg(CFG_GAIN, GainReset);
        random_items(100);
        settle();

        repeat (3) begin
            write_cfg(CFG_OFFSET, $urandom_range(0, 2000) - 1000);
            write_cfg(CFG_PERIOD, $urandom_range(100000, 2000000));
            write_cfg(CFG_GAIN, $urandom_range(0, 65535));
            random_items(70);
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
